### rtl/swtm_pkg.sv
// Shared widths, constants and register indexes of the sliding-window throughput meter.
// Used by swtm_div, sliding_window_throughput_meter and the test bench files; depends on nothing.
package swtm_pkg;

	localparam int DEPTH_DEF = 1024;

	localparam int SEC_W  = 32;
	localparam int NSEC_W = 30;
	localparam int LEN_W  = 16;
	localparam int TIME_W = 62;
	localparam int RATE_W = 33;
	localparam int SUM_W  = 26;
	localparam int ENT_W  = 11;
	localparam int SPAN_W = 32;
	localparam int MINI_W = 30;
	localparam int CFG_W  = 32;
	localparam int PROD_W = SUM_W + NSEC_W;
	localparam int QHI_W  = PROD_W - RATE_W;
	localparam int DCNT_W = $clog2(RATE_W + 1);

	localparam int IN_W  = ((SEC_W + NSEC_W + LEN_W + 7) / 8) * 8;
	localparam int OUT_W = ((RATE_W + SUM_W + ENT_W + 7) / 8) * 8;

	localparam logic [NSEC_W-1:0] ONE_SEC_NS = 30'd1000000000;

	localparam logic [SPAN_W-1:0] SPAN_RST = 32'd1000000000;
	localparam logic [MINI_W-1:0] MINI_RST = 30'd10000000;

	localparam logic REG_WINDOW_SPAN  = 1'b0;
	localparam logic REG_MIN_INTERVAL = 1'b1;

endpackage

### rtl/sliding_window_throughput_meter.sv
// Top level of the sliding-window throughput meter: packet ring, eviction sequencer, output.
// Depends on swtm_pkg and swtm_div.
//
// One word at a time. A zero-length word goes straight from the timestamp to the output step.
// Any other word runs eviction, the window update and the rate: each eviction is a read of the
// ring's single registered read port followed by an age check; the rate comes from a divider
// at one quotient bit per cycle (saturation skips its bit steps, an empty window skips it).
// A reading still waiting on m_tready holds the next word at its output step.
// The ring has no reset; only held records are ever read.
module sliding_window_throughput_meter
	import swtm_pkg::*;
#(
	parameter int WINDOW_DEPTH = DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [IN_W-1:0]    s_tdata,   // time_sec[31:0], time_nsec[61:32], payload_len[77:62]
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_W-1:0]   m_tdata,   // throughput[32:0], window_bytes[58:33], window_entries[69:59]
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);

	localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int REC_W = LEN_W + TIME_W;

	typedef enum logic [10:0] {
		ST_IDLE = 11'b00000000001,
		ST_MUL  = 11'b00000000010,
		ST_NOW  = 11'b00000000100,
		ST_EVRD = 11'b00000001000,
		ST_EVCK = 11'b00000010000,
		ST_FULL = 11'b00000100000,
		ST_HDRD = 11'b00001000000,
		ST_SPAN = 11'b00010000000,
		ST_DVGO = 11'b00100000000,
		ST_DIV  = 11'b01000000000,
		ST_OUT  = 11'b10000000000
	} state_t;

	state_t               state_q;
	logic [SPAN_W-1:0]    span_q;
	logic [MINI_W-1:0]    mini_q;
	logic [SEC_W-1:0]     sec_q;
	logic [NSEC_W-1:0]    nsec_q;
	logic [LEN_W-1:0]     len_q;
	logic [TIME_W-1:0]    mul_q;
	logic [TIME_W-1:0]    now_q;
	logic [TIME_W-1:0]    tv_q;
	logic [IDX_W-1:0]     head_q;
	logic [CNT_W-1:0]     count_q;
	logic [SUM_W-1:0]     sum_q;
	logic [RATE_W-1:0]    rate_q;
	logic                 push_q;
	logic                 m_tvalid_q;
	logic [OUT_W-1:0]     m_tdata_q;

	logic [REC_W-1:0]     ram [WINDOW_DEPTH];
	logic [REC_W-1:0]     rd_q;
	logic                 wr_en;
	logic [IDX_W-1:0]     tail;
	logic [CNT_W:0]       tail_sum;

	logic [TIME_W-1:0]    rd_time;
	logic [LEN_W-1:0]     rd_len;
	logic [TIME_W:0]      dif;
	logic                 dif_pos;
	logic [MINI_W-1:0]    floor_ns;
	logic [SEC_W-1:0]     mul_a;
	logic [IDX_W-1:0]     head_nx;
	logic                 full;
	logic [31:0]          cnt_ext;
	logic                 out_load;

	logic                 div_start;
	logic                 div_done;
	logic [RATE_W-1:0]    div_quot;

	assign rd_time  = rd_q[TIME_W-1:0];
	assign rd_len   = rd_q[REC_W-1:TIME_W];
	assign dif      = {1'b0, now_q} - {1'b0, rd_time};
	assign dif_pos  = !dif[TIME_W] && (dif[TIME_W-1:0] != '0);
	assign floor_ns = (mini_q == '0) ? MINI_W'(1) : mini_q;
	assign head_nx  = (head_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign full     = count_q == CNT_W'(WINDOW_DEPTH);
	assign tail_sum = (CNT_W+1)'(head_q) + (CNT_W+1)'(count_q);
	assign tail     = (tail_sum >= (CNT_W+1)'(WINDOW_DEPTH))
		? IDX_W'(tail_sum - (CNT_W+1)'(WINDOW_DEPTH)) : IDX_W'(tail_sum);
	assign mul_a    = (state_q == ST_SPAN) ? SEC_W'(sum_q) : sec_q;
	assign cnt_ext  = 32'(count_q);
	assign div_start = state_q == ST_DVGO;
	assign wr_en    = push_q;
	assign out_load = (state_q == ST_OUT) && !push_q && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ram[tail] <= {len_q, now_q};
		end
		rd_q <= ram[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q <= SPAN_RST;
			mini_q <= MINI_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_SPAN:  span_q <= cfg_data;
				REG_MIN_INTERVAL: mini_q <= cfg_data[MINI_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			sec_q      <= '0;
			nsec_q     <= '0;
			len_q      <= '0;
			mul_q      <= '0;
			now_q      <= '0;
			tv_q       <= '0;
			head_q     <= '0;
			count_q    <= '0;
			sum_q      <= '0;
			rate_q     <= '0;
			push_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			push_q <= ((state_q == ST_SPAN) && (count_q == '0))
				|| ((state_q == ST_DIV) && div_done);
			if (push_q) begin
				count_q <= count_q + 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						sec_q   <= s_tdata[SEC_W-1:0];
						nsec_q  <= s_tdata[SEC_W+NSEC_W-1:SEC_W];
						len_q   <= s_tdata[SEC_W+NSEC_W+LEN_W-1:SEC_W+NSEC_W];
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					mul_q   <= TIME_W'(mul_a) * TIME_W'(ONE_SEC_NS);
					state_q <= ST_NOW;
				end
				ST_NOW: begin
					now_q   <= mul_q + TIME_W'(nsec_q);
					state_q <= (len_q == '0) ? ST_OUT : ST_EVRD;
				end
				ST_EVRD: begin
					state_q <= (count_q == '0) ? ST_FULL : ST_EVCK;
				end
				ST_EVCK: begin
					if (dif_pos && dif[TIME_W-1:0] > TIME_W'(span_q)) begin
						sum_q   <= sum_q - SUM_W'(rd_len);
						head_q  <= head_nx;
						count_q <= count_q - 1'b1;
						state_q <= ST_EVRD;
					end else begin
						state_q <= ST_FULL;
					end
				end
				ST_FULL: begin
					if (full) begin
						sum_q   <= sum_q - SUM_W'(rd_len) + SUM_W'(len_q);
						head_q  <= head_nx;
						count_q <= count_q - 1'b1;
					end else begin
						sum_q <= sum_q + SUM_W'(len_q);
					end
					state_q <= ST_HDRD;
				end
				ST_HDRD: begin
					state_q <= ST_SPAN;
				end
				ST_SPAN: begin
					if (count_q == '0) begin
						rate_q  <= '0;
						state_q <= ST_OUT;
					end else begin
						tv_q <= (dif_pos && dif[TIME_W-1:0] > TIME_W'(floor_ns))
							? dif[TIME_W-1:0] : TIME_W'(floor_ns);
						mul_q   <= TIME_W'(mul_a) * TIME_W'(ONE_SEC_NS);
						state_q <= ST_DVGO;
					end
				end
				ST_DVGO: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						rate_q  <= div_quot;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						m_tdata_q <= OUT_W'({cnt_ext[ENT_W-1:0], sum_q, rate_q});
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	swtm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mul_q[PROD_W-1:0]),
		.divisor  (tv_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(WINDOW_DEPTH))
		else $error("entry count beyond ring depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= IDX_W'(WINDOW_DEPTH - 1))
		else $error("head index beyond ring depth");

	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider result outside division state");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push_q |=> count_q == $past(count_q) + 1'b1)
		else $error("push did not add one record");

endmodule

### rtl/swtm_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, saturating at RATE_W bits.
// Depends on swtm_pkg.
module swtm_div
	import swtm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [PROD_W-1:0]   dividend,
	input  logic [TIME_W-1:0]   divisor,
	output logic                done,
	output logic [RATE_W-1:0]   quotient
);

	logic                running_q;
	logic                done_q;
	logic [DCNT_W-1:0]   cnt_q;
	logic [PROD_W-1:0]   rem_q;
	logic [RATE_W-1:0]   dq_q;
	logic [TIME_W-1:0]   dvs_q;
	logic [PROD_W:0]     trial;
	logic                take;
	logic                sat;

	assign trial = {rem_q, dq_q[RATE_W-1]};
	assign take  = TIME_W'(trial) >= dvs_q;
	assign sat   = TIME_W'(dividend[PROD_W-1:RATE_W]) >= divisor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
			rem_q     <= '0;
			dq_q      <= '0;
			dvs_q     <= '0;
		end else begin
			done_q <= start ? sat : (running_q && cnt_q == DCNT_W'(1));
			if (start) begin
				dvs_q <= divisor;
				if (sat) begin
					dq_q <= '1;
				end else begin
					rem_q     <= PROD_W'(dividend[PROD_W-1:RATE_W]);
					dq_q      <= dividend[RATE_W-1:0];
					cnt_q     <= DCNT_W'(RATE_W);
					running_q <= 1'b1;
				end
			end else if (running_q) begin
				if (take) begin
					rem_q <= PROD_W'(TIME_W'(trial) - dvs_q);
				end else begin
					rem_q <= trial[PROD_W-1:0];
				end
				dq_q  <= {dq_q[RATE_W-2:0], take};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_W'(1)) begin
					running_q <= 1'b0;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> TIME_W'(rem_q) < dvs_q)
		else $error("divider remainder not below divisor");

	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !running_q)
		else $error("divider done while still running");

	a_no_start_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> !start)
		else $error("divider restarted while busy");

endmodule

### test/swtm_rate_checker.sv
// Scoreboard for the sliding-window throughput meter: follows the input, output and register
// ports, keeps its own packet ring and byte sum, predicts every reading and compares it.
// Depends on swtm_pkg.
module swtm_rate_checker
	import swtm_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // time_sec[31:0], time_nsec[61:32], payload_len[77:62]
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [OUT_W-1:0] m_tdata,   // throughput[32:0], window_bytes[58:33], window_entries[69:59]
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output int               mismatches,
	output int               outstanding,
	output int               readings,
	output int               peak_held
);

	typedef struct packed {
		logic [ENT_W-1:0]  window_entries;
		logic [SUM_W-1:0]  window_bytes;
		logic [RATE_W-1:0] throughput;
	} reading_t;

	localparam longint unsigned NS_PER_S = 64'd1000000000;
	localparam longint unsigned RATE_CAP = (64'd1 << RATE_W) - 64'd1;

	logic [TIME_W-1:0] held_ns  [DEPTH];
	logic [LEN_W-1:0]  held_len [DEPTH];
	int unsigned       oldest;
	int unsigned       held;
	logic [SUM_W-1:0]  sum_bytes;
	logic [RATE_W-1:0] rate;
	logic [SPAN_W-1:0] span_ns;
	logic [MINI_W-1:0] floor_ns;
	reading_t          pending_readings[$];

	task automatic drop_oldest();
		sum_bytes = sum_bytes - held_len[oldest];
		oldest = (oldest + 1) % DEPTH;
		held--;
	endtask

	task automatic predict_reading(input logic [SEC_W-1:0] sec, input logic [NSEC_W-1:0] nsec,
			input logic [LEN_W-1:0] len);
		longint unsigned now;
		longint          age;
		longint          lo;
		longint          gap;
		longint unsigned quo;
		int unsigned     tail;
		reading_t        r;
		now = 64'(sec) * NS_PER_S + 64'(nsec);
		if (len != '0) begin
			// age-out, oldest first; a stamp from the future never ages out
			while (held > 0) begin
				age = longint'(now) - longint'({2'b00, held_ns[oldest]});
				if (age > 0 && age > longint'({32'd0, span_ns}))
					drop_oldest();
				else
					break;
			end
			if (held >= DEPTH)
				drop_oldest();
			sum_bytes = sum_bytes + len;
			if (held == 0) begin
				rate = '0;
			end else begin
				age = longint'(now) - longint'({2'b00, held_ns[oldest]});
				lo = (floor_ns == '0) ? 64'd1 : 64'(floor_ns);
				gap = (age > lo) ? age : lo;
				quo = (64'(sum_bytes) * NS_PER_S) / gap;
				rate = (quo > RATE_CAP) ? '1 : quo[RATE_W-1:0];
			end
			tail = (oldest + held) % DEPTH;
			held_ns[tail] = now[TIME_W-1:0];
			held_len[tail] = len;
			held++;
			if (held > peak_held)
				peak_held = held;
		end
		r.throughput = rate;
		r.window_bytes = sum_bytes;
		r.window_entries = held[ENT_W-1:0];
		pending_readings.push_back(r);
	endtask

	task automatic check_reading(input logic [OUT_W-1:0] word);
		reading_t got;
		reading_t want;
		got = reading_t'(word[RATE_W+SUM_W+ENT_W-1:0]);
		readings++;
		if (pending_readings.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected reading: rate %0d, bytes %0d, entries %0d", $realtime,
					got.throughput, got.window_bytes, got.window_entries);
		end else begin
			want = pending_readings.pop_front();
			if (got.throughput !== want.throughput || got.window_bytes !== want.window_bytes
					|| got.window_entries !== want.window_entries) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: reading %0d: rate %0d/%0d bytes %0d/%0d entries %0d/%0d (exp/got)",
						$realtime, readings, want.throughput, got.throughput, want.window_bytes,
						got.window_bytes, want.window_entries, got.window_entries);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest = 0;
			held = 0;
			sum_bytes = '0;
			rate = '0;
			span_ns = SPAN_RST;
			floor_ns = MINI_RST;
			pending_readings.delete();
			mismatches = 0;
			outstanding = 0;
			readings = 0;
			peak_held = 0;
		end else begin
			// a reading leaving now can never belong to a word entering now
			if (m_tvalid && m_tready)
				check_reading(m_tdata);
			if (s_tvalid && s_tready)
				predict_reading(s_tdata[SEC_W-1:0], s_tdata[SEC_W+NSEC_W-1:SEC_W],
					s_tdata[SEC_W+NSEC_W+LEN_W-1:SEC_W+NSEC_W]);
			if (cfg_we) begin
				if (cfg_index == REG_WINDOW_SPAN)
					span_ns = cfg_data[SPAN_W-1:0];
				else
					floor_ns = cfg_data[MINI_W-1:0];
			end
			outstanding = pending_readings.size();
		end
	end

endmodule

### test/tb_sliding_window_throughput_meter.sv
// Testbench top for the sliding-window throughput meter: clock, reset, packet stimulus,
// window settings and verdict. Depends on swtm_pkg, sliding_window_throughput_meter and
// swtm_rate_checker.
module tb_sliding_window_throughput_meter;
	import swtm_pkg::*;

	localparam longint unsigned NS_PER_S = 64'd1000000000;
	localparam longint unsigned LAST_NS  = 64'd4294967295 * NS_PER_S + 64'd999999999;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;   // time_sec[31:0], time_nsec[61:32], payload_len[77:62]
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;   // throughput[32:0], window_bytes[58:33], window_entries[69:59]
	logic             cfg_we;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_data;

	int              mismatches;
	int              outstanding;
	int              readings;
	int              peak_held;
	bit              steady;
	int              words_sent;
	int              zero_words;
	int              settings_used;
	longint unsigned clock_ns;

	sliding_window_throughput_meter u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	swtm_rate_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.outstanding(outstanding),
		.readings   (readings),
		.peak_held  (peak_held)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 13);
	end

	task automatic send_word(input logic [SEC_W-1:0] sec, input logic [NSEC_W-1:0] nsec,
			input logic [LEN_W-1:0] len);
		while (!steady && $urandom_range(99) < 13) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_W'({len, nsec, sec});
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		@(posedge clk);
		words_sent++;
		if (len == '0)
			zero_words++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	// both registers are rewritten only once every reading is out
	task automatic set_window(input logic [CFG_W-1:0] span, input logic [CFG_W-1:0] lo);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_WINDOW_SPAN;
		cfg_data  <= span;
		@(posedge clk);
		cfg_index <= REG_MIN_INTERVAL;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_used++;
		clock_ns = 64'($urandom) * NS_PER_S + 64'($urandom_range(999999999));
	endtask

	task automatic random_run(input int count, input int unsigned stride, input int noise_pct,
			input bit jumps);
		logic [SEC_W-1:0]  sec;
		logic [NSEC_W-1:0] nsec;
		logic [LEN_W-1:0]  len;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < noise_pct) begin
				sec  = $urandom;
				nsec = NSEC_W'($urandom_range(30'h3FFFFFFF));
				len  = LEN_W'($urandom);
			end else begin
				case ($urandom_range(15))
					0: begin
						if (clock_ns > stride)
							clock_ns -= $urandom_range(stride);
					end
					1: begin
						if (jumps)
							clock_ns += 64'($urandom) * 3;
					end
					default: clock_ns += $urandom_range(stride);
				endcase
				if (clock_ns > LAST_NS)
					clock_ns = 64'($urandom_range(1000)) * NS_PER_S;
				sec  = SEC_W'(clock_ns / NS_PER_S);
				nsec = NSEC_W'(clock_ns % NS_PER_S);
				// same instant written with an over-range nanosecond count
				if (sec != '0 && nsec < 30'd73741824 && $urandom_range(1) == 0) begin
					sec  = sec - 1'b1;
					nsec = nsec + ONE_SEC_NS;
				end
				case ($urandom_range(9))
					0: len = '0;
					1: len = 16'hFFFF;
					2, 3: len = LEN_W'($urandom_range(64));
					default: len = LEN_W'($urandom);
				endcase
			end
			send_word(sec, nsec, len);
		end
	endtask

	initial begin
		#15_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_we    = 1'b0;
		cfg_index = REG_WINDOW_SPAN;
		cfg_data  = '0;
		steady    = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: empty window, short and negative intervals, age-out, extreme stamps
		send_word(32'd0, 30'd0, 16'd0);
		send_word(32'd0, 30'd0, 16'hFFFF);
		send_word(32'd0, 30'd5000000, 16'd1);
		send_word(32'd0, 30'd500000000, 16'd100);
		send_word(32'd0, 30'd1000, 16'd7);
		send_word(32'd0, 30'd0, 16'd0);
		send_word(32'd0, 30'h3FFFFFFF, 16'd3);
		send_word(32'd5, 30'd0, 16'd9);
		send_word(32'd5, 30'd999999999, 16'h8000);
		send_word(32'hFFFFFFFF, 30'h3FFFFFFF, 16'hFFFF);
		send_word(32'hFFFFFFFF, 30'd0, 16'd1);
		send_word(32'd0, 30'd0, 16'd2);
		send_word(32'd0, 30'd0, 16'd0);

		// 1 ns span, floor masked down to zero: saturated rates
		set_window(32'd1, 32'hC000_0000);
		send_word(32'd9, 30'd0, 16'hFFFF);
		send_word(32'd9, 30'd0, 16'hFFFF);
		send_word(32'd9, 30'd1, 16'd5);
		send_word(32'd9, 30'd3, 16'd5);
		random_run(60, 4, 8, 1'b1);

		set_window(32'(SPAN_RST), 32'(MINI_RST));
		random_run(40, 50_000_000, 8, 1'b1);
		drain();
		random_run(40, 50_000_000, 8, 1'b1);

		// full-scale span and widest floor: long run with a deep window
		set_window(32'hFFFFFFFF, 32'hFFFFFFFF);
		steady = 1'b1;
		random_run(150, 1_000_000, 0, 1'b0);
		steady = 1'b0;
		random_run(150, 1_000_000, 0, 1'b0);

		set_window(32'd4000000000, 32'd1000000000);
		random_run(50, 400_000_000, 8, 1'b1);

		set_window(32'd1000, 32'd10000000);
		random_run(45, 2000, 8, 1'b1);

		drain();
		repeat (60) @(posedge clk);
		$display("covered %0d packets (%0d zero-length), %0d readings checked, peak occupancy %0d",
			words_sent, zero_words, readings, peak_held);
		$display("window settings: %0d, from 1 ns to full-scale span, floors from zero to max",
			settings_used + 1);
		if (mismatches == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
